[rtl/core/qdbn_pkg.sv]
// Package with the shared constants, codes and types of the quantized dense neuron core.
package qdbn_pkg;

   localparam int QDBN_ACC_WIDTH = 32;
   localparam int QDBN_SHAMT_W   = 8;
   localparam int QDBN_CSR_IDX_W = 4;
   localparam int QDBN_CSR_DAT_W = 8;

   localparam logic [3:0] QDBN_RST_INPUT_FRAC  = 4'd4;
   localparam logic [3:0] QDBN_RST_WEIGHT_FRAC = 4'd8;
   localparam logic [3:0] QDBN_RST_BIAS_FRAC   = 4'd8;
   localparam logic [3:0] QDBN_RST_OUT_FRAC    = 4'd2;
   localparam logic [3:0] QDBN_RST_SCALE_FRAC  = 4'd4;
   localparam logic [3:0] QDBN_RST_OFFSET_FRAC = 4'd5;

   typedef enum logic [QDBN_CSR_IDX_W-1:0] {
      CSR_INPUT_FRAC  = 4'd0,
      CSR_WEIGHT_FRAC = 4'd1,
      CSR_BIAS_FRAC   = 4'd2,
      CSR_OUT_FRAC    = 4'd3,
      CSR_SCALE_FRAC  = 4'd4,
      CSR_OFFSET_FRAC = 4'd5,
      CSR_RELU_ENABLE = 4'd6,
      CSR_NORM_ENABLE = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [3:0] input_frac;
      logic [3:0] weight_frac;
      logic [3:0] bias_frac;
      logic [3:0] out_frac;
      logic [3:0] scale_frac;
      logic [3:0] offset_frac;
      logic       relu_enable;
      logic       norm_enable;
   } cfg_type;

   typedef enum logic [1:0] {
      ALU_ADD   = 2'd0,
      ALU_MUL   = 2'd1,
      ALU_SHIFT = 2'd2
   } alu_op_type;

   typedef struct packed {
      alu_op_type                     op;
      logic signed [QDBN_SHAMT_W-1:0] shamt;
   } alu_ctl_type;

endpackage

[rtl/core/qdbn_ifs.sv]
// Handshake interfaces of the quantized dense neuron core.
interface qdbn_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] activation;
   logic signed [7:0] weight_value;
   logic signed [7:0] bias_value;
   logic signed [7:0] norm_scale;
   logic signed [7:0] norm_offset;
   logic              last;

   modport source (output valid, activation, weight_value, bias_value, norm_scale,
                   norm_offset, last, input ready);
   modport sink (input valid, activation, weight_value, bias_value, norm_scale,
                 norm_offset, last, output ready);
endinterface

interface qdbn_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] result_value;
   logic              overflow;

   modport source (output valid, result_value, overflow, input ready);
   modport sink (input valid, result_value, overflow, output ready);
endinterface

interface qdbn_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [qdbn_pkg::QDBN_CSR_IDX_W-1:0] index;
   logic [qdbn_pkg::QDBN_CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/quantized_dense_bn_neuron_core.sv]
// Top level of the quantized dense neuron core: sequencer around one shared ALU.
// A pair without last runs acceptance, product and accumulate; the next is taken in idle.
// A last pair then runs bias shift and bias add, with batch norm on scale multiply,
// offset shift and offset add, and requantize, which registers the result for rsp_bus.
// The single ALU does one add, multiply or shift per cycle, unless the output stalls.
// Synchronous reset clears the sequencer, accumulator and output valid, and loads the CSRs.
module quantized_dense_bn_neuron_core #(
   parameter int ACC_WIDTH = qdbn_pkg::QDBN_ACC_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   qdbn_req_if.sink   req_bus,
   qdbn_rsp_if.source rsp_bus,
   qdbn_csr_if.sink   csr_bus
);
   import qdbn_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_MUL      = 9'b000000010,
      S_MAC      = 9'b000000100,
      S_BIAS_SH  = 9'b000001000,
      S_BIAS_ADD = 9'b000010000,
      S_SCL_MUL  = 9'b000100000,
      S_OFS_SH   = 9'b001000000,
      S_OFS_ADD  = 9'b010000000,
      S_REQ      = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   cfg_type   cfg;

   logic [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic [ACC_WIDTH-1:0] tmp_ff, tmp_in;
   logic signed [7:0]    act_ff, wgt_ff, bias_ff, scale_ff, offs_ff;
   logic                 last_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [7:0]    rsp_value_ff;
   logic                 rsp_ovf_ff;

   alu_ctl_type          alu_ctl;
   logic [ACC_WIDTH-1:0] alu_a, alu_b, alu_y;

   logic signed [QDBN_SHAMT_W-1:0] fi, fw, fb, fo, fs, fof;
   logic signed [QDBN_SHAMT_W-1:0] k_bias, k_offs, k_out;
   logic                           out_free;
   logic                           req_take;

   qdbn_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   qdbn_alu #(.ACC_WIDTH(ACC_WIDTH)) u_alu (
      .ctl (alu_ctl),
      .opa (alu_a),
      .opb (alu_b),
      .res (alu_y)
   );

   assign fi  = $signed({{(QDBN_SHAMT_W-4){1'b0}}, cfg.input_frac});
   assign fw  = $signed({{(QDBN_SHAMT_W-4){1'b0}}, cfg.weight_frac});
   assign fb  = $signed({{(QDBN_SHAMT_W-4){1'b0}}, cfg.bias_frac});
   assign fo  = $signed({{(QDBN_SHAMT_W-4){1'b0}}, cfg.out_frac});
   assign fs  = $signed({{(QDBN_SHAMT_W-4){1'b0}}, cfg.scale_frac});
   assign fof = $signed({{(QDBN_SHAMT_W-4){1'b0}}, cfg.offset_frac});

   assign k_bias = fi + fw - fb;
   assign k_offs = fi + fw + fs - fof;
   assign k_out  = cfg.norm_enable ? (fo - fi - fw - fs) : (fo - fi - fw);

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_value = rsp_value_ff;
   assign rsp_bus.overflow     = rsp_ovf_ff;

   // ALU operand selection per sequencer step.
   always_comb begin
      alu_ctl.op    = ALU_ADD;
      alu_ctl.shamt = '0;
      alu_a         = acc_ff;
      alu_b         = tmp_ff;
      case (state_ff)
         S_MUL: begin
            alu_ctl.op = ALU_MUL;
            alu_a      = {{(ACC_WIDTH-8){act_ff[7]}}, act_ff};
            alu_b      = {{(ACC_WIDTH-8){wgt_ff[7]}}, wgt_ff};
         end
         S_BIAS_SH: begin
            alu_ctl.op    = ALU_SHIFT;
            alu_ctl.shamt = k_bias;
            alu_a         = {{(ACC_WIDTH-8){bias_ff[7]}}, bias_ff};
         end
         S_SCL_MUL: begin
            alu_ctl.op = ALU_MUL;
            alu_b      = {{(ACC_WIDTH-8){scale_ff[7]}}, scale_ff};
         end
         S_OFS_SH: begin
            alu_ctl.op    = ALU_SHIFT;
            alu_ctl.shamt = k_offs;
            alu_a         = {{(ACC_WIDTH-8){offs_ff[7]}}, offs_ff};
         end
         S_REQ: begin
            alu_ctl.op    = ALU_SHIFT;
            alu_ctl.shamt = k_out;
            // ReLU: a negative sum enters the requantizer as zero.
            alu_a         = (cfg.relu_enable && acc_ff[ACC_WIDTH-1]) ? '0 : acc_ff;
         end
         default: begin
            alu_ctl.op = ALU_ADD;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            tmp_in   = alu_y;
            state_in = S_MAC;
         end
         S_MAC: begin
            acc_in   = alu_y;
            state_in = last_ff ? S_BIAS_SH : S_IDLE;
         end
         S_BIAS_SH: begin
            tmp_in   = alu_y;
            state_in = S_BIAS_ADD;
         end
         S_BIAS_ADD: begin
            acc_in   = alu_y;
            state_in = cfg.norm_enable ? S_SCL_MUL : S_REQ;
         end
         S_SCL_MUL: begin
            acc_in   = alu_y;
            state_in = S_OFS_SH;
         end
         S_OFS_SH: begin
            tmp_in   = alu_y;
            state_in = S_OFS_ADD;
         end
         S_OFS_ADD: begin
            acc_in   = alu_y;
            state_in = S_REQ;
         end
         S_REQ: begin
            // Wait here while the previous result is still held on the output.
            if (out_free) begin
               acc_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tmp_ff <= tmp_in;
      if (req_take) begin
         act_ff   <= req_bus.activation;
         wgt_ff   <= req_bus.weight_value;
         bias_ff  <= req_bus.bias_value;
         scale_ff <= req_bus.norm_scale;
         offs_ff  <= req_bus.norm_offset;
         last_ff  <= req_bus.last;
      end
      if (state_ff == S_REQ && out_free) begin
         rsp_value_ff <= alu_y[7:0];
         // Out of int8 range unless every bit from bit 7 upward is the same.
         rsp_ovf_ff   <= !((&alu_y[ACC_WIDTH-1:7]) || !(|alu_y[ACC_WIDTH-1:7]));
      end
   end

`ifndef NO_ASSERTIONS
   a_take_starts_mul : assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_MUL))
      else $error("accepted transaction did not start the product step");

   a_rsp_from_req : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_REQ))
      else $error("result appeared without a requantize step");

   a_acc_cleared : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (acc_ff == '0))
      else $error("accumulator not cleared after a result");

   a_no_req_when_busy : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REQ && !out_free) |=> (state_ff == S_REQ))
      else $error("requantize step left while output was stalled");
`endif

endmodule

[rtl/core/qdbn_alu.sv]
// Shared add, multiply and signed-shift unit of the neuron core.
module qdbn_alu #(
   parameter int ACC_WIDTH = qdbn_pkg::QDBN_ACC_WIDTH
) (
   input  qdbn_pkg::alu_ctl_type  ctl,
   input  logic [ACC_WIDTH-1:0]   opa,
   input  logic [ACC_WIDTH-1:0]   opb,
   output logic [ACC_WIDTH-1:0]   res
);
   import qdbn_pkg::*;

   localparam logic signed [QDBN_SHAMT_W-1:0] ACC_S   = QDBN_SHAMT_W'(ACC_WIDTH);
   localparam logic        [QDBN_SHAMT_W-1:0] MAX_RSH = QDBN_SHAMT_W'(ACC_WIDTH - 1);

   logic signed [ACC_WIDTH+7:0]    prod;
   logic        [QDBN_SHAMT_W-1:0] lsh;
   logic        [QDBN_SHAMT_W-1:0] rsh_raw;
   logic        [QDBN_SHAMT_W-1:0] rsh;
   logic        [ACC_WIDTH-1:0]    shifted;

   // The second multiplier operand is always an int8 value.
   assign prod    = $signed(opa) * $signed(opb[7:0]);
   assign lsh     = ctl.shamt;
   assign rsh_raw = -ctl.shamt;
   assign rsh     = (rsh_raw > MAX_RSH) ? MAX_RSH : rsh_raw;

   always_comb begin
      if ($signed(ctl.shamt) > 0) begin
         if ($signed(ctl.shamt) >= ACC_S) begin
            shifted = '0;
         end else begin
            shifted = opa << lsh;
         end
      end else begin
         shifted = $signed(opa) >>> rsh;
      end
   end

   always_comb begin
      case (ctl.op)
         ALU_ADD:   res = opa + opb;
         ALU_MUL:   res = prod[ACC_WIDTH-1:0];
         ALU_SHIFT: res = shifted;
         default:   res = opa;
      endcase
   end

endmodule

[rtl/core/qdbn_csr.sv]
// Configuration register file of the neuron core.
module qdbn_csr (
   input  logic                clock,
   input  logic                reset,
   qdbn_csr_if.sink            csr_bus,
   output qdbn_pkg::cfg_type   cfg
);
   import qdbn_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_INPUT_FRAC:  cfg_in.input_frac  = csr_bus.data[3:0];
            CSR_WEIGHT_FRAC: cfg_in.weight_frac = csr_bus.data[3:0];
            CSR_BIAS_FRAC:   cfg_in.bias_frac   = csr_bus.data[3:0];
            CSR_OUT_FRAC:    cfg_in.out_frac    = csr_bus.data[3:0];
            CSR_SCALE_FRAC:  cfg_in.scale_frac  = csr_bus.data[3:0];
            CSR_OFFSET_FRAC: cfg_in.offset_frac = csr_bus.data[3:0];
            CSR_RELU_ENABLE: cfg_in.relu_enable = csr_bus.data[0];
            CSR_NORM_ENABLE: cfg_in.norm_enable = csr_bus.data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_frac  <= QDBN_RST_INPUT_FRAC;
         cfg_ff.weight_frac <= QDBN_RST_WEIGHT_FRAC;
         cfg_ff.bias_frac   <= QDBN_RST_BIAS_FRAC;
         cfg_ff.out_frac    <= QDBN_RST_OUT_FRAC;
         cfg_ff.scale_frac  <= QDBN_RST_SCALE_FRAC;
         cfg_ff.offset_frac <= QDBN_RST_OFFSET_FRAC;
         cfg_ff.relu_enable <= 1'b0;
         cfg_ff.norm_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
